/* rtl/core/length_prefix_to_start_code_macros.svh */
// assertion macros for the length-prefix to start-code converter
// used by the port checker; no other dependencies
`ifndef LENGTH_PREFIX_TO_START_CODE_MACROS_SVH
`define LENGTH_PREFIX_TO_START_CODE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lpsc implication check failed");

// next-cycle implication, disabled during reset
`define LPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lpsc next-cycle check failed");

`endif

/* rtl/core/lpsc_pkg.sv */
// shared types and constants for the length-prefix to start-code converter
// no dependencies
package lpsc_pkg;

	localparam int MAX_PACKET_BYTES = 4096;
	localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int ENTRY_W = 10;

	// store entry layout: byte, prefix marker, last-prefix-byte marker
	localparam int TAG_PREFIX_BIT = 8;
	localparam int TAG_PREFIX_END_BIT = 9;

	typedef enum logic [2:0] {
		ST_BYTE        = 3'd0,
		ST_CONVERTED   = 3'd1,
		ST_PASSTHROUGH = 3'd2,
		ST_TOO_LONG    = 3'd3,
		ST_EMPTY       = 3'd4
	} status_t;

	// store write from the load parser
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} store_wr_t;

	// verdict at the last byte of a packet
	typedef struct packed {
		logic             fire;
		logic             too_long;
		logic             convert;
		logic [CNT_W-1:0] length;
	} verdict_t;

endpackage

/* rtl/core/lpsc_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
module lpsc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/lpsc_parse.sv */
// load-side parser: tags bytes for the store and tracks the length-prefix structure
// depends on lpsc_pkg
module lpsc_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [7:0]          data_byte,
	input  logic                last,
	output lpsc_pkg::store_wr_t wr,
	output lpsc_pkg::verdict_t  verdict
);
	import lpsc_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [1:0]       hidx_q, hidx_n;
	logic [31:0]      acc_q, acc_n;
	logic [31:0]      left_q, left_n;
	logic             seen_q, seen_n;
	logic             bad_q, bad_n;
	logic [31:0]      head_q, head_n;
	logic             ovf_q, ovf_n;
	logic [1:0]       tag;
	logic [31:0]      acc_sh;
	logic             start_code;
	logic             units_ok;

	assign acc_sh = {acc_q[23:0], data_byte};

	// next load state for one byte
	always_comb begin
		cnt_n  = cnt_q;
		hidx_n = hidx_q;
		acc_n  = acc_q;
		left_n = left_q;
		seen_n = seen_q;
		bad_n  = bad_q;
		head_n = head_q;
		ovf_n  = ovf_q;
		tag    = 2'b00;
		if (cnt_q < CNT_W'(MAX_PACKET_BYTES)) begin
			if (cnt_q < CNT_W'(4)) begin
				head_n = {head_q[23:0], data_byte};
			end
			if (left_q != 32'd0) begin
				left_n = left_q - 32'd1;
			end else begin
				tag   = 2'b01;
				acc_n = acc_sh;
				if (hidx_q == 2'd3) begin
					tag = 2'b11;
					if (acc_sh == 32'd0) begin
						bad_n = 1'b1;
					end else begin
						seen_n = 1'b1;
					end
					left_n = acc_sh;
					acc_n  = 32'd0;
					hidx_n = 2'd0;
				end else begin
					hidx_n = hidx_q + 2'd1;
				end
			end
			cnt_n = cnt_q + CNT_W'(1);
		end else begin
			ovf_n = 1'b1;
		end
	end

	// store write
	always_comb begin
		wr.we   = load && (cnt_q < CNT_W'(MAX_PACKET_BYTES));
		wr.addr = cnt_q[ADDR_W-1:0];
		wr.data = {tag, data_byte};
	end

	// verdict on the final byte
	assign start_code = (cnt_n >= CNT_W'(4)) &&
		((head_n[31:8] == 24'h000001) || (head_n == 32'h00000001));
	assign units_ok = !bad_n && seen_n && (hidx_n == 2'd0) && (left_n == 32'd0);

	always_comb begin
		verdict.fire     = load && last;
		verdict.too_long = ovf_n;
		verdict.convert  = !start_code && units_ok;
		verdict.length   = cnt_n;
	end

	// load state, cleared after every verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hidx_q <= '0;
			acc_q  <= '0;
			left_q <= '0;
			seen_q <= 1'b0;
			bad_q  <= 1'b0;
			head_q <= '0;
			ovf_q  <= 1'b0;
		end else if (load) begin
			if (last) begin
				cnt_q  <= '0;
				hidx_q <= '0;
				acc_q  <= '0;
				left_q <= '0;
				seen_q <= 1'b0;
				bad_q  <= 1'b0;
				head_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				cnt_q  <= cnt_n;
				hidx_q <= hidx_n;
				acc_q  <= acc_n;
				left_q <= left_n;
				seen_q <= seen_n;
				bad_q  <= bad_n;
				head_q <= head_n;
				ovf_q  <= ovf_n;
			end
		end
	end

endmodule

/* rtl/core/length_prefix_to_start_code.sv */
// Length-prefix to start-code converter, top level.
// Input channel (in_valid/in_stall): kind 0 loads data_byte of a packet, last
// marks its final byte; kind 1 asks for the next drained byte.
// Output channel (out_valid/out_stall): one result per read and per final
// load byte; non-final loads give no result.
// Loads are taken one per cycle while the input is not stalled, and are written
// straight into the packet store; the final load's verdict (converted,
// passthrough, too_long) is in the output register the cycle after acceptance.
// A read that drains a byte passes through the store's registered read port,
// and the byte is then formed into the output register; the input stalls
// meanwhile. A read with nothing to drain answers in the next cycle with the empty status.
// No new load or read is taken while a drained byte is still on its way
// from the store's read port to the output register.
// Store writes and drain reads never overlap, as a read is only issued
// after all loads of the packet have been written.
// Reset clears all control state and drops any pending packet; the store
// contents are not cleared and are never read before being written.
// When the receiver stalls, the result holds; loads without last keep
// flowing, anything that would make a new result waits.
module length_prefix_to_start_code (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [7:0]                data_byte,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [7:0]                out_byte,
	output logic                      end_of_packet,
	output logic [lpsc_pkg::CNT_W-1:0] packet_length
);
	import lpsc_pkg::*;

	logic               in_fire, load_fire, read_fire, out_fire;
	store_wr_t          wr;
	verdict_t           verdict;
	logic [ENTRY_W-1:0] rdata;
	logic               empty;
	logic [CNT_W-1:0]   ptr_inc;

	logic [CNT_W-1:0] drain_ptr_q, drain_len_q;
	logic             drain_conv_q, drain_act_q;
	logic             rd_pend_s1, rd_eop_s1;

	logic             out_valid_q;
	status_t          status_q;
	logic [7:0]       byte_q;
	logic             eop_q;
	logic [CNT_W-1:0] len_q;
	logic [7:0]       rd_value;

	// handshake
	assign in_stall  = rd_pend_s1 || (out_valid_q && out_stall && (kind || last));
	assign in_fire   = in_valid && !in_stall;
	assign load_fire = in_fire && !kind;
	assign read_fire = in_fire && kind;
	assign out_fire  = out_valid_q && !out_stall;

	lpsc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_fire),
		.data_byte (data_byte),
		.last      (last),
		.wr        (wr),
		.verdict   (verdict)
	);

	assign empty   = !drain_act_q || (drain_ptr_q >= drain_len_q);
	assign ptr_inc = drain_ptr_q + CNT_W'(1);

	lpsc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PACKET_BYTES)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (read_fire && !empty),
		.raddr (drain_ptr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_ptr_q  <= '0;
			drain_len_q  <= '0;
			drain_conv_q <= 1'b0;
			drain_act_q  <= 1'b0;
			rd_pend_s1   <= 1'b0;
			rd_eop_s1    <= 1'b0;
		end else begin
			rd_pend_s1 <= read_fire && !empty;
			if (load_fire) begin
				drain_act_q <= 1'b0;
				if (verdict.fire && !verdict.too_long) begin
					drain_ptr_q  <= '0;
					drain_len_q  <= verdict.length;
					drain_conv_q <= verdict.convert;
					drain_act_q  <= verdict.length != '0;
				end
			end else if (read_fire) begin
				if (empty) begin
					drain_act_q <= 1'b0;
				end else begin
					drain_ptr_q <= ptr_inc;
					rd_eop_s1   <= ptr_inc >= drain_len_q;
					if (ptr_inc >= drain_len_q) begin
						drain_act_q <= 1'b0;
					end
				end
			end
		end
	end

	// prefix bytes become the start code when converting
	always_comb begin
		rd_value = rdata[7:0];
		if (drain_conv_q && rdata[TAG_PREFIX_BIT]) begin
			rd_value = rdata[TAG_PREFIX_END_BIT] ? 8'h01 : 8'h00;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_EMPTY;
			byte_q      <= '0;
			eop_q       <= 1'b0;
			len_q       <= '0;
		end else begin
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
				status_q    <= ST_BYTE;
				byte_q      <= rd_value;
				eop_q       <= rd_eop_s1;
				len_q       <= '0;
			end else if (read_fire && empty) begin
				out_valid_q <= 1'b1;
				status_q    <= ST_EMPTY;
				byte_q      <= '0;
				eop_q       <= 1'b0;
				len_q       <= '0;
			end else if (verdict.fire) begin
				out_valid_q <= 1'b1;
				status_q    <= verdict.too_long ? ST_TOO_LONG :
					(verdict.convert ? ST_CONVERTED : ST_PASSTHROUGH);
				byte_q      <= '0;
				eop_q       <= 1'b0;
				len_q       <= verdict.length;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_byte      = byte_q;
	assign end_of_packet = eop_q;
	assign packet_length = len_q;

endmodule

/* rtl/core/lpsc_checker.sv */
// port-level checker for the length-prefix to start-code converter
// depends on lpsc_pkg and length_prefix_to_start_code_macros.svh
`include "length_prefix_to_start_code_macros.svh"

module lpsc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [2:0]                 status,
	input logic [7:0]                 out_byte,
	input logic                       end_of_packet,
	input logic [lpsc_pkg::CNT_W-1:0] packet_length
);
	import lpsc_pkg::*;

	// a stalled transaction holds
	`LPSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(out_byte) && $stable(end_of_packet) && $stable(packet_length))

	// only byte transactions carry a byte or an end marker
	`LPSC_ASSERT_IMPL(a_non_byte_clear, clk, arst_n, out_valid && (status != ST_BYTE), (out_byte == 8'd0) && !end_of_packet)

	// byte and empty transactions carry no length
	`LPSC_ASSERT_IMPL(a_len_zero, clk, arst_n, out_valid && ((status == ST_BYTE) || (status == ST_EMPTY)), packet_length == '0)

	// an overlong packet reports the full store size
	`LPSC_ASSERT_IMPL(a_too_long_len, clk, arst_n, out_valid && (status == ST_TOO_LONG), packet_length == CNT_W'(MAX_PACKET_BYTES))

endmodule

bind length_prefix_to_start_code lpsc_checker u_lpsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.out_byte      (out_byte),
	.end_of_packet (end_of_packet),
	.packet_length (packet_length)
);
